[sv/annexb_pkg.sv]
// Shared types and constants for the Annex B NAL unit splitter.
// Used by annexb_scan, annexb_tagger, the top level and the checker.
package annexb_pkg;

  localparam int BYTE_W     = 8;
  localparam int TYPE_W     = 5;
  localparam int PREFIX_W   = 3;
  localparam int LIMIT_W    = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int HOLD_MAX   = 4;
  localparam int WIN_LEN    = HOLD_MAX + 1;
  localparam int HELD_W     = 3;
  localparam int QDEPTH     = 8;
  localparam int QAW        = 3;
  localparam int QCNT_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DROP_DELIMITERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_LIMIT      = 2'd1;

  localparam logic [BYTE_W-1:0]   TYPE_MASK      = 8'h1f;
  localparam logic [TYPE_W-1:0]   DELIMITER_TYPE = 5'h09;
  localparam logic [PREFIX_W-1:0] PREFIX_SHORT   = 3'd3;
  localparam logic [PREFIX_W-1:0] PREFIX_LONG    = 3'd4;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET    = 21'h100000;
  localparam logic [LIMIT_W-1:0]  LIMIT_FLOOR    = 21'd8;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              stream_end;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   payload_byte;
    logic [TYPE_W-1:0]   unit_type;
    logic                unit_first;
    logic                unit_last;
    logic [PREFIX_W-1:0] prefix_length;
    logic                truncated;
  } out_t;

  // One queued operation: an optional byte to give, then optional actions.
  typedef struct packed {
    logic              give;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              start;
    logic              long_prefix;
    logic              restart;
  } op_t;

  typedef struct packed {
    logic               drop_delimiters;
    logic [LIMIT_W-1:0] unit_limit;
  } cfg_t;

endpackage

[sv/annexb_scan.sv]
// Start code scanner: holds up to four recent bytes and turns each input
// byte into up to five queued operations. Depends on annexb_pkg.
module annexb_scan (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  annexb_pkg::in_t                        in_item,
  output annexb_pkg::op_t [annexb_pkg::WIN_LEN-1:0] ops,
  output logic [annexb_pkg::HELD_W-1:0]          n_ops
);

  logic [annexb_pkg::HOLD_MAX-1:0][annexb_pkg::BYTE_W-1:0] rb_r, rb_nxt;
  logic [annexb_pkg::HELD_W-1:0] held_r, held_nxt;

  logic [annexb_pkg::WIN_LEN-1:0][annexb_pkg::BYTE_W-1:0] q;
  logic [annexb_pkg::HELD_W-1:0] len, tz, zc, pre, z, keep, base, n_give, flag_idx, idx;
  logic is_start, is_end, flagged;

  always_comb begin
    len = held_r + 3'd1;
    for (int i = 0; i < annexb_pkg::WIN_LEN; i++) begin
      if (3'(i) < held_r) q[i] = rb_r[i];
      else if (3'(i) == held_r) q[i] = in_item.data_byte;
      else q[i] = '0;
    end
    // trailing zero run of the held bytes
    tz = '0;
    for (int i = 0; i < annexb_pkg::HOLD_MAX; i++) begin
      if (3'(i) < held_r) begin
        if (rb_r[i] == '0) tz = tz + 3'd1;
        else tz = '0;
      end
    end
    is_end   = in_item.stream_end;
    is_start = (in_item.data_byte == 8'd1) && (tz >= 3'd2);
    zc       = (tz > 3'd3) ? 3'd3 : tz;
    pre      = held_r - zc;
    z        = (in_item.data_byte == '0) ? tz + 3'd1 : 3'd0;
    keep     = ((z > 3'd3) ? 3'd3 : z) + 3'd1;
    if (keep > len) keep = len;
    base     = len - keep;

    for (int j = 0; j < annexb_pkg::HOLD_MAX; j++) begin
      idx = base + 3'(j);
      rb_nxt[j] = (idx < 3'(annexb_pkg::WIN_LEN)) ? q[idx] : '0;
    end

    if (is_start)    n_give = pre;
    else if (is_end) n_give = len;
    else             n_give = base;
    flagged  = is_start || is_end;
    flag_idx = (n_give != '0) ? n_give - 3'd1 : 3'd0;
    n_ops    = (n_give != '0) ? n_give : {2'b00, flagged};
    held_nxt = flagged ? 3'd0 : keep;

    for (int k = 0; k < annexb_pkg::WIN_LEN; k++) begin
      ops[k].give        = 3'(k) < n_give;
      ops[k].data        = q[k];
      ops[k].last        = flagged && (n_give != '0) && (3'(k) == flag_idx);
      ops[k].start       = is_start && (3'(k) == flag_idx);
      ops[k].long_prefix = (zc == 3'd3);
      ops[k].restart     = is_end && (3'(k) == flag_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (en) begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rb_r <= rb_nxt;
    end
  end

endmodule

[sv/annexb_tagger.sv]
// Unit tagger: applies one op per cycle with pop high, tracking sync, header,
// type, byte count and truncation, and forms the result item. Uses annexb_pkg.
module annexb_tagger #(
  parameter int MAX_UNIT_BYTES = 1048576
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop,
  input  annexb_pkg::op_t  op,
  input  annexb_pkg::cfg_t cfg,
  output logic             emit,
  output annexb_pkg::out_t res
);

  localparam int CNT_W = $clog2(MAX_UNIT_BYTES + 2);
  localparam int LW    = (CNT_W > annexb_pkg::LIMIT_W) ? CNT_W : annexb_pkg::LIMIT_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_UNIT_BYTES);

  logic synced_r, synced_nxt;
  logic dropping_r, dropping_nxt;
  logic awaiting_r, awaiting_nxt;
  logic [annexb_pkg::TYPE_W-1:0]   type_r, type_nxt;
  logic [annexb_pkg::PREFIX_W-1:0] prefix_r, prefix_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [LW-1:0]    lim_wide;
  logic [CNT_W-1:0] lim, count_inc;

  always_comb begin
    lim_wide = LW'(cfg.unit_limit);
    if (lim_wide < LW'(annexb_pkg::LIMIT_FLOOR)) lim_wide = LW'(annexb_pkg::LIMIT_FLOOR);
    if (lim_wide > MAX_L) lim_wide = MAX_L;
    lim       = lim_wide[CNT_W-1:0];
    count_inc = count_r + CNT_W'(1);
  end

  always_comb begin
    logic [annexb_pkg::TYPE_W-1:0] type_v;
    logic first, skip, last, trunc;
    synced_nxt   = synced_r;
    dropping_nxt = dropping_r;
    awaiting_nxt = awaiting_r;
    type_nxt     = type_r;
    prefix_nxt   = prefix_r;
    count_nxt    = count_r;
    emit         = 1'b0;
    type_v       = type_r;
    first        = 1'b0;
    skip         = 1'b0;
    last         = op.last;
    trunc        = 1'b0;
    if (pop) begin
      if (op.give && synced_r && !dropping_r) begin
        if (awaiting_r) begin
          awaiting_nxt = 1'b0;
          first        = 1'b1;
          type_v       = annexb_pkg::TYPE_W'(op.data & annexb_pkg::TYPE_MASK);
          type_nxt     = type_v;
          if (cfg.drop_delimiters && type_v == annexb_pkg::DELIMITER_TYPE) begin
            dropping_nxt = 1'b1;
            skip         = 1'b1;
          end
        end
        if (!skip) begin
          count_nxt = count_inc;
          if (!op.last && count_inc >= lim) begin
            last         = 1'b1;
            trunc        = 1'b1;
            dropping_nxt = 1'b1;
          end
          emit = 1'b1;
        end
      end
      if (op.start) begin
        synced_nxt   = 1'b1;
        dropping_nxt = 1'b0;
        awaiting_nxt = 1'b1;
        prefix_nxt   = op.long_prefix ? annexb_pkg::PREFIX_LONG : annexb_pkg::PREFIX_SHORT;
        count_nxt    = CNT_W'(prefix_nxt);
      end
      if (op.restart) begin
        synced_nxt   = 1'b0;
        dropping_nxt = 1'b0;
        awaiting_nxt = 1'b0;
        type_nxt     = '0;
        prefix_nxt   = annexb_pkg::PREFIX_SHORT;
        count_nxt    = '0;
      end
    end
    res.payload_byte  = op.data;
    res.unit_type     = type_v;
    res.unit_first    = first;
    res.unit_last     = last;
    res.prefix_length = prefix_r;
    res.truncated     = trunc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synced_r   <= 1'b0;
      dropping_r <= 1'b0;
      awaiting_r <= 1'b0;
      type_r     <= '0;
      prefix_r   <= annexb_pkg::PREFIX_SHORT;
      count_r    <= '0;
    end else begin
      synced_r   <= synced_nxt;
      dropping_r <= dropping_nxt;
      awaiting_r <= awaiting_nxt;
      type_r     <= type_nxt;
      prefix_r   <= prefix_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

[sv/annexb_nal_unit_splitter_unit.sv]
// Top level of the Annex B NAL unit splitter: scanner, operation queue,
// tagger and output register. Depends on annexb_pkg, annexb_scan, annexb_tagger.
//
// The block takes one stream byte per clock while in_ready is high and gives
// NAL unit bytes with start codes (00 00 01 and 00 00 00 01) removed, at most
// one result per clock. Each input transaction is turned at once by the scanner
// into up to five queued operations (bytes released from the four-byte hold
// window, plus start code and stream restart actions) that enter an eight-entry
// queue; in_ready is high while that queue holds three entries or fewer, so one
// byte is taken every cycle in steady flow. The tagger drains one operation per
// cycle, while the output register is empty or being taken, into the output
// register, which keeps its result until out_ready. A start code with no byte
// ahead of it, a dropped delimiter header and every byte that is discarded
// (before sync or after a cut) each use up a queued operation without a result.
// Held zeros that turn out not to open a start code are released together, and
// a stream end can release up to five bytes from one transaction; these bursts,
// and a stalled out_ready, are what may briefly hold in_ready low. Configuration
// writes are accepted every cycle (cfg_ready is high) and must be made while the
// block is idle; unknown indexes are ignored.
module annexb_nal_unit_splitter_unit #(
  parameter int MAX_UNIT_BYTES = 1048576
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  annexb_pkg::in_t                       in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output annexb_pkg::out_t                      out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [annexb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [annexb_pkg::LIMIT_W-1:0]        cfg_data
);

  annexb_pkg::cfg_t cfg_r;

  annexb_pkg::op_t [annexb_pkg::WIN_LEN-1:0] ops;
  logic [annexb_pkg::HELD_W-1:0]             n_ops;
  logic                                      in_fire;

  annexb_pkg::op_t                 q_mem [annexb_pkg::QDEPTH];
  logic [annexb_pkg::QAW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [annexb_pkg::QCNT_W-1:0]   cnt_r;
  logic                            pop;
  logic [annexb_pkg::HELD_W-1:0]   push_n;

  logic             emit;
  annexb_pkg::out_t res;
  logic             out_valid_r;
  annexb_pkg::out_t out_data_r;

  // Accept while the queue can take a full burst.
  assign in_ready  = cnt_r <= annexb_pkg::QCNT_W'(annexb_pkg::QDEPTH - annexb_pkg::WIN_LEN);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign push_n    = in_fire ? n_ops : '0;
  assign pop       = (cnt_r != '0) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drop_delimiters <= 1'b1;
      cfg_r.unit_limit      <= annexb_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        annexb_pkg::CFG_DROP_DELIMITERS: cfg_r.drop_delimiters <= cfg_data[0];
        annexb_pkg::CFG_UNIT_LIMIT:      cfg_r.unit_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  annexb_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (in_fire),
    .in_item (in_data),
    .ops     (ops),
    .n_ops   (n_ops)
  );

  // Operation queue: write the burst at consecutive slots, read at the head.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < annexb_pkg::WIN_LEN; k++) begin
        if (3'(k) < n_ops) q_mem[wr_ptr_r + annexb_pkg::QAW'(k)] <= ops[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + annexb_pkg::QAW'(push_n);
      rd_ptr_r <= rd_ptr_r + annexb_pkg::QAW'(pop);
      cnt_r    <= cnt_r + annexb_pkg::QCNT_W'(push_n) - annexb_pkg::QCNT_W'(pop);
    end
  end

  annexb_tagger #(
    .MAX_UNIT_BYTES (MAX_UNIT_BYTES)
  ) u_tagger (
    .clk   (clk),
    .rst_n (rst_n),
    .pop   (pop),
    .op    (q_mem[rd_ptr_r]),
    .cfg   (cfg_r),
    .emit  (emit),
    .res   (res)
  );

  // Output register: load on a giving pop, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/annexb_checker.sv]
// Port-level checks for the Annex B NAL unit splitter, bound to the top level.
// Depends on annexb_pkg and annexb_nal_unit_splitter_unit.
module annexb_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input annexb_pkg::out_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.truncated |-> out_data.unit_last)
    else $error("truncated flag off the final byte");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.prefix_length == annexb_pkg::PREFIX_SHORT ||
                   out_data.prefix_length == annexb_pkg::PREFIX_LONG))
    else $error("bad prefix length");

  a_header_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unit_first |->
      out_data.unit_type == out_data.payload_byte[annexb_pkg::TYPE_W-1:0])
    else $error("unit type does not match header byte");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind annexb_nal_unit_splitter_unit annexb_checker u_annexb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/annexb_nal_unit_splitter_unit_tb.sv]
// Self-checking testbench for the Annex B NAL unit splitter top level.
// Depends on annexb_pkg and annexb_nal_unit_splitter_unit; predicts every unit
// byte in a local stream model and checks each output transaction against it.
module annexb_nal_unit_splitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_UNIT_BYTES = 1048576;
  // Budget for the slowest legal run, several times over.
  localparam int CYCLE_LIMIT    = 400000;
  // Cycles to let the drain queue empty after the last expected byte.
  localparam int SETTLE_CYCLES  = 32;

  // Indexes the block must ignore.
  localparam logic [annexb_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [annexb_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  annexb_pkg::in_t                  in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  annexb_pkg::out_t                 out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [annexb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [annexb_pkg::LIMIT_W-1:0]   cfg_data  = '0;

  annexb_nal_unit_splitter_unit #(
    .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Stream model: hold window, sync and unit tracking, plus register shadows.
  // ---------------------------------------------------------------------------
  logic [annexb_pkg::BYTE_W-1:0]   held_bytes [annexb_pkg::HOLD_MAX];
  int                              held_n;
  bit                              synced_q;
  bit                              dropping_q;
  bit                              awaiting_header_q;
  logic [annexb_pkg::TYPE_W-1:0]   unit_type_q;
  logic [annexb_pkg::PREFIX_W-1:0] prefix_q;
  int unsigned                     unit_count_q;
  bit                              drop_delim_reg;
  logic [annexb_pkg::LIMIT_W-1:0]  limit_reg;

  annexb_pkg::out_t unit_bytes_due [$];   // unit bytes predicted but not yet seen
  annexb_pkg::in_t  stream_plan [$];      // stream bytes waiting to be offered

  int error_count        = 0;
  int bytes_sent         = 0;
  int bytes_checked      = 0;
  int truncations_seen   = 0;
  int reg_writes         = 0;
  int input_stall_cycles = 0;
  int cycle_count        = 0;
  int hold_off_left      = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  // Out-of-range limits clamp to the floor and to the build-time maximum.
  function automatic int unsigned active_limit();
    if (limit_reg < annexb_pkg::LIMIT_FLOOR) return 32'(annexb_pkg::LIMIT_FLOOR);
    if (limit_reg > MAX_UNIT_BYTES) return MAX_UNIT_BYTES;
    return 32'(limit_reg);
  endfunction

  function automatic void restart_stream();
    foreach (held_bytes[i]) held_bytes[i] = '0;
    held_n            = 0;
    synced_q          = 1'b0;
    dropping_q        = 1'b0;
    awaiting_header_q = 1'b0;
    unit_type_q       = '0;
    prefix_q          = annexb_pkg::PREFIX_SHORT;
    unit_count_q      = 0;
  endfunction

  // Hand one settled byte to the current unit. Drop it while unsynced or while
  // the unit is being discarded; latch the type on the header byte.
  function automatic void release_unit_byte(logic [annexb_pkg::BYTE_W-1:0] b, bit last_in);
    bit               is_last;
    bit               is_first;
    bit               is_trunc;
    annexb_pkg::out_t r;
    is_last  = last_in;
    is_first = 1'b0;
    is_trunc = 1'b0;
    if (!synced_q || dropping_q) return;
    if (awaiting_header_q) begin
      awaiting_header_q = 1'b0;
      is_first          = 1'b1;
      unit_type_q       = annexb_pkg::TYPE_W'(b & annexb_pkg::TYPE_MASK);
      if (drop_delim_reg && unit_type_q == annexb_pkg::DELIMITER_TYPE) begin
        dropping_q = 1'b1;
        return;
      end
    end
    unit_count_q++;
    // Cut the unit at the limit unless this byte already ends it.
    if (!is_last && unit_count_q >= active_limit()) begin
      is_last    = 1'b1;
      is_trunc   = 1'b1;
      dropping_q = 1'b1;
    end
    r.payload_byte  = b;
    r.unit_type     = unit_type_q;
    r.unit_first    = is_first;
    r.unit_last     = is_last;
    r.prefix_length = prefix_q;
    r.truncated     = is_trunc;
    unit_bytes_due.push_back(r);
  endfunction

  // Advance the model by one accepted stream byte.
  function automatic void split_stream_byte(annexb_pkg::in_t item);
    logic [annexb_pkg::BYTE_W-1:0] win [annexb_pkg::WIN_LEN];
    int n;
    int zeros;
    int zc;
    int ahead;
    int z;
    int keep;
    n = held_n;
    for (int i = 0; i < n; i++) win[i] = held_bytes[i];
    win[n] = item.data_byte;
    n++;
    // Count zeros right before the new byte.
    zeros = 0;
    while (zeros < n - 1 && win[n - 2 - zeros] == 8'h00) zeros++;
    if (item.data_byte == 8'h01 && zeros >= 2) begin
      // Start code: at most the last three zeros belong to it; earlier zeros are
      // unit bytes, and the last byte ahead of the code closes the previous unit.
      zc    = (zeros > 3) ? 3 : zeros;
      ahead = n - 1 - zc;
      for (int i = 0; i < ahead; i++) release_unit_byte(win[i], i + 1 == ahead);
      synced_q          = 1'b1;
      dropping_q        = 1'b0;
      awaiting_header_q = 1'b1;
      prefix_q          = (zc == 3) ? annexb_pkg::PREFIX_LONG : annexb_pkg::PREFIX_SHORT;
      unit_count_q      = 32'(prefix_q);
      held_n            = 0;
    end else begin
      // Hold the trailing zero run (at most three) and the byte ahead of it.
      z = 0;
      while (z < n && win[n - 1 - z] == 8'h00) z++;
      keep = ((z > 3) ? 3 : z) + 1;
      if (keep > n) keep = n;
      for (int i = 0; i < n - keep; i++) release_unit_byte(win[i], 1'b0);
      for (int i = 0; i < keep; i++) held_bytes[i] = win[n - keep + i];
      held_n = keep;
    end
    if (item.stream_end) begin
      // Flush whatever is held, the final byte closing the unit.
      for (int i = 0; i < held_n; i++) release_unit_byte(held_bytes[i], i + 1 == held_n);
      restart_stream();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare each output transaction with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_unit_bytes
    annexb_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (unit_bytes_due.size() == 0) begin
        $display("%0t: unexpected unit byte, expected none, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = unit_bytes_due.pop_front();
        compare_field("payload_byte",  want.payload_byte, out_data.payload_byte);
        compare_field("unit_type",     8'(want.unit_type), 8'(out_data.unit_type));
        compare_field("unit_first",    8'(want.unit_first), 8'(out_data.unit_first));
        compare_field("unit_last",     8'(want.unit_last), 8'(out_data.unit_last));
        compare_field("prefix_length", 8'(want.prefix_length),
                      8'(out_data.prefix_length));
        compare_field("truncated",     8'(want.truncated), 8'(out_data.truncated));
        bytes_checked++;
        if (want.truncated) truncations_seen++;
      end
    end
  end

  // Receiver: a long hold-off when requested, otherwise the current pattern.
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left--;
    end else begin
      case (ready_mode)
        READY_ALWAYS: begin
          out_ready <= 1'b1;
        end
        READY_COIN: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        READY_SPARSE: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= ((cycle_count % 9) < 5);
        end
      endcase
    end
  end

  // Watchdog, plus a count of cycles where the block pushed back on input.
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && in_ready === 1'b0) input_stall_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d unit bytes outstanding",
               $time, cycle_count, unit_bytes_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_byte(logic [annexb_pkg::BYTE_W-1:0] b, bit is_end);
    stream_plan.push_back(annexb_pkg::in_t'{data_byte: b, stream_end: is_end});
  endfunction

  // Queue count bytes from a packed literal, most significant byte first.
  function automatic void queue_bytes(logic [127:0] seq, int count);
    for (int k = 0; k < count; k++) queue_byte(seq[8 * (count - 1 - k) +: 8], 1'b0);
  endfunction

  function automatic void end_stream_here();
    annexb_pkg::in_t item;
    item            = stream_plan.pop_back();
    item.stream_end = 1'b1;
    stream_plan.push_back(item);
  endfunction

  // Body bytes lean toward zeros and ones so that near-start codes show up.
  function automatic logic [annexb_pkg::BYTE_W-1:0] random_body_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return 8'h00;
    if (pick < 38) return 8'h01;
    if (pick < 42) return 8'h03;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [annexb_pkg::BYTE_W-1:0] random_header();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return {3'($urandom_range(0, 7)), annexb_pkg::DELIMITER_TYPE};
    if (pick < 19) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_unit(int zero_run, logic [annexb_pkg::BYTE_W-1:0] header,
                                   int body_len, bit end_after);
    repeat (zero_run) queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(header, 1'b0);
    repeat (body_len) queue_byte(random_body_byte(), 1'b0);
    if (end_after) end_stream_here();
  endfunction

  // Mostly well-formed units with random content; some noise, broken start
  // codes and empty units mixed in.
  function automatic void plan_random_stream(int n_items);
    int target;
    int pick;
    int zero_run;
    int body_len;
    target = stream_plan.size() + n_items;
    while (stream_plan.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 6))
          queue_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                     $urandom_range(0, 49) == 0);
      end else if (pick < 13) begin
        repeat ($urandom_range(2, 3)) queue_byte(8'h00, 1'b0);
        queue_byte(8'($urandom_range(2, 255)), 1'b0);
      end else if (pick < 17) begin
        queue_bytes(128'h000001, 3);
      end else begin
        pick     = $urandom_range(0, 99);
        zero_run = (pick < 45) ? 2 : (pick < 90) ? 3 : $urandom_range(4, 6);
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        add_unit(zero_run, random_header(), body_len, $urandom_range(0, 99) < 6);
      end
    end
  endfunction

  // One input transaction; valid stays up across a burst.
  task automatic send_stream_byte(annexb_pkg::in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    split_stream_byte(item);
    bytes_sent++;
  endtask

  // Offer the planned bytes in bursts of random length; drop valid for a
  // random gap between bursts when max_gap is nonzero.
  task automatic offer_stream(int max_gap);
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 16);
    foreach (stream_plan[i]) begin
      send_stream_byte(stream_plan[i]);
      burst_left--;
      if (burst_left == 0 && i + 1 < stream_plan.size()) begin
        burst_left = $urandom_range(1, 16);
        gap        = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    stream_plan.delete();
  endtask

  // Wait for every predicted byte, then let dropped work drain out.
  task automatic wait_until_drained();
    while (unit_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [annexb_pkg::CFG_IDX_W-1:0] index,
                                logic [annexb_pkg::LIMIT_W-1:0] value);
    wait_until_drained();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      annexb_pkg::CFG_DROP_DELIMITERS: drop_delim_reg = value[0];
      annexb_pkg::CFG_UNIT_LIMIT:      limit_reg      = value;
      default: ;  // unknown index, no effect
    endcase
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: leading junk, both start code lengths, held zeros that do
  // not start a code, a long zero run, a dropped delimiter, an empty unit and a
  // stream end that flushes a trailing zero.
  task automatic test_directed_cases();
    ready_mode = READY_ALWAYS;
    queue_bytes(128'hff_00000001_67_000002_0000000001, 14);
    queue_bytes(128'h09f0_000001_000001_1f80, 10);
    queue_byte(8'h00, 1'b1);
    offer_stream(0);
  endtask

  // Register corners: kept delimiter, truncation at the floor limit, a unit
  // that ends exactly at the limit, ignored indexes, clamped limits and a
  // limit lowered in the middle of a unit.
  task automatic test_register_corners();
    ready_mode = READY_COIN;
    write_register(annexb_pkg::CFG_DROP_DELIMITERS, 21'd0);
    write_register(annexb_pkg::CFG_UNIT_LIMIT, annexb_pkg::LIMIT_FLOOR);
    queue_bytes(128'h000001_09_aa, 5);
    queue_bytes(128'h00000001_65_112233445566, 11);
    queue_bytes(128'h000001_41_12345678, 8);
    queue_bytes(128'h000001, 3);
    offer_stream(3);
    write_register(CFG_SPARE_A, 21'h1fffff);
    write_register(CFG_SPARE_B, 21'h000001);
    write_register(annexb_pkg::CFG_UNIT_LIMIT, 21'h1fffff);
    queue_bytes(128'h06_a1a2a3a4, 5);
    offer_stream(0);
    // Drop below the floor mid-unit: the next settled byte is cut.
    write_register(annexb_pkg::CFG_UNIT_LIMIT, 21'd0);
    queue_bytes(128'hb1b2b3_000001, 6);
    end_stream_here();
    offer_stream(2);
    write_register(annexb_pkg::CFG_DROP_DELIMITERS, 21'd1);
    write_register(annexb_pkg::CFG_UNIT_LIMIT, annexb_pkg::LIMIT_RESET);
  endtask

  // Random streams over several settings and idling patterns.
  task automatic test_random_stream();
    logic [annexb_pkg::LIMIT_W-1:0] limit_pick;
    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      case (phase_no)
        0:       limit_pick = annexb_pkg::LIMIT_FLOOR;
        1:       limit_pick = annexb_pkg::LIMIT_RESET;
        2:       limit_pick = annexb_pkg::LIMIT_W'($urandom_range(9, 40));
        3:       limit_pick = annexb_pkg::LIMIT_W'($urandom_range(0, 7));
        4:       limit_pick = 21'h1fffff;
        default: limit_pick = annexb_pkg::LIMIT_W'($urandom_range(12, 64));
      endcase
      write_register(annexb_pkg::CFG_DROP_DELIMITERS, annexb_pkg::LIMIT_W'(phase_no % 2));
      write_register(annexb_pkg::CFG_UNIT_LIMIT, limit_pick);
      ready_mode = ready_mode_t'(phase_no % 4);
      plan_random_stream(55);
      offer_stream((phase_no % 3 == 0) ? 0 : 2 * phase_no);
    end
  endtask

  // Hold the receiver off long enough for the queue to fill while bytes keep
  // coming back to back, so the input has to stall.
  task automatic test_receiver_hold_off();
    wait_until_drained();
    ready_mode    = READY_ALWAYS;
    hold_off_left = 400;
    plan_random_stream(45);
    offer_stream(0);
  endtask

  initial begin
    restart_stream();
    drop_delim_reg = 1'b1;
    limit_reg      = annexb_pkg::LIMIT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_register_corners();
    test_random_stream();
    test_receiver_hold_off();

    wait_until_drained();
    $display("Sent %0d stream bytes and %0d register writes; checked %0d unit bytes",
             bytes_sent, reg_writes, bytes_checked);
    $display("including %0d truncated units; input held off for %0d cycles",
             truncations_seen, input_stall_cycles);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
